FILE: src/vtc_pkg.sv
// ----------------------------------------------------------------------------
// vtc_pkg: shared constants and tables for the voice trigger clip crusher
// Sizes, request codes and the crush output table.
// ----------------------------------------------------------------------------
package vtc_pkg;

    localparam int CLIP_FRAMES   = 4096;
    localparam int CLIP_AW       = $clog2(CLIP_FRAMES);
    localparam int LEN_W         = $clog2(CLIP_FRAMES + 1);
    localparam int MAX_BLOCK     = 4096;
    localparam int BLK_W         = $clog2(MAX_BLOCK + 1);
    localparam int SUM_W         = 43;
    localparam int RESAMPLE_STEP = 88474;
    localparam int MIN_CLIP      = 64;
    localparam int CRUSH_LEVELS  = 28;

    typedef enum logic [2:0] {
        REQ_SAMPLE  = 3'd0,
        REQ_UPDATE  = 3'd1,
        REQ_CONSUME = 3'd2,
        REQ_PULL    = 3'd3,
        REQ_EMPTY   = 3'd4
    } t_req;

    // q * 32767 / 28, truncated, for q = 0..28
    localparam logic [15:0] CRUSH_OUT [0:CRUSH_LEVELS] = '{
        16'd0,     16'd1170,  16'd2340,  16'd3510,  16'd4681,  16'd5851,
        16'd7021,  16'd8191,  16'd9362,  16'd10532, 16'd11702, 16'd12872,
        16'd14043, 16'd15213, 16'd16383, 16'd17553, 16'd18724, 16'd19894,
        16'd21064, 16'd22234, 16'd23405, 16'd24575, 16'd25745, 16'd26915,
        16'd28086, 16'd29256, 16'd30426, 16'd31596, 16'd32767
    };

    function automatic logic [15:0] crush_out(input logic [4:0] q);
        logic [15:0] v;
        v = 16'd32767;
        if (q <= 5'(CRUSH_LEVELS)) v = CRUSH_OUT[q];
        return v;
    endfunction

endpackage

FILE: src/vtc_ram.sv
// ----------------------------------------------------------------------------
// vtc_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module vtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/voice_trigger_clip_pitch_crusher.sv
// ----------------------------------------------------------------------------
// voice_trigger_clip_pitch_crusher: level trigger, clip recorder, crusher
// RMS level per block, threshold trigger, clip capture and 1.35x resampled,
// bit-crushed playback, all on one multiplier and one shared subtractor.
// ----------------------------------------------------------------------------
//
//  channel   handshake                    payload
//  -------   ---------------------------  ------------------------------------
//  input     i_in_valid / o_in_ready      req_type, sample, first_channel,
//                                         block_end, max_frames
//  output    o_out_valid / i_out_ready    out_sample, sample_valid, last, ok,
//                                         frame_count, triggered
//  config    i_cfg_we                     i_cfg_index, i_cfg_data
//
//  A sample is squared and accumulated; on a block end a bit-serial divide
//  and a two-bit-per-step square root follow on the shared subtractor.
//  Update, consume and empty items are handled in the execute state; a
//  render pull reads the single clip RAM port twice, then interpolates.
//  Results sit in an output register; the next item is accepted while one
//  waits, and an item that produces a result holds until the slot is free.
//  Reset is synchronous and clears all control state; the clip RAM is not
//  cleared, since only entries written since the last trigger are read.
//
module voice_trigger_clip_pitch_crusher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic signed [15:0] i_sample,
    input  logic        i_first_channel,
    input  logic        i_block_end,
    input  logic [15:0] i_max_frames,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [15:0] o_out_sample,
    output logic        o_sample_valid,
    output logic        o_last,
    output logic        o_ok,
    output logic [15:0] o_frame_count,
    output logic        o_triggered
);

    localparam int LW = vtc_pkg::LEN_W;
    localparam int AW = vtc_pkg::CLIP_AW;
    localparam int BW = vtc_pkg::BLK_W;
    localparam int SW = vtc_pkg::SUM_W;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SQ, S_ACC, S_DIV, S_SQRT,
        S_R0, S_R1, S_R2, S_R3, S_R4, S_R5, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [14:0] r_trig_lvl, r_rel_lvl;

    // latched item
    logic [2:0]         r_req;
    logic signed [15:0] r_sample;
    logic               r_first, r_bend;
    logic [15:0]        r_maxf;

    // detector and clip state
    logic [SW-1:0] r_sum;
    logic [BW-1:0] r_blk;
    logic [15:0]   r_level;
    logic          r_armed, r_pend, r_rec, r_clip_ready;
    logic [LW-1:0] r_len;
    logic [15:0]   r_ridx;

    // iterative divide / square root
    logic [SW-1:0] r_quo;
    logic [19:0]   r_rem;
    logic [31:0]   r_rad;
    logic [15:0]   r_root;
    logic [5:0]    r_step;

    // render datapath
    logic signed [35:0] r_prod;
    logic [16:0]        r_base;
    logic [15:0]        r_frac;
    logic signed [15:0] r_s0;
    logic [36:0]        r_mag28;
    logic               r_neg;

    // result waiting to go into the output register
    logic signed [15:0] r_res_sample;
    logic r_res_sv, r_res_last, r_res_ok, r_res_trig;
    logic [15:0] r_res_fc;

    // output register
    logic               r_ovalid;
    logic signed [15:0] r_o_sample;
    logic r_o_sv, r_o_last, r_o_ok, r_o_trig;
    logic [15:0] r_o_fc;

    // ---------------- shared multiplier ----------------
    logic signed [17:0] mul_a, mul_b;
    logic [15:0]        ram_rdata;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = 18'(r_sample);
                mul_b = 18'(r_sample);
            end
            S_R0: begin
                mul_a = $signed({2'b00, r_ridx});
                mul_b = 18'(vtc_pkg::RESAMPLE_STEP);
            end
            S_R3: begin
                mul_a = 18'($signed(ram_rdata)) - 18'(r_s0);
                mul_b = $signed({2'b00, r_frac});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- shared subtractor ----------------
    logic [19:0] su_a, su_b, su_diff;
    logic        su_ge;

    always_comb begin
        if (r_state == S_SQRT) begin
            su_a = {r_rem[17:0], r_rad[31:30]};
            su_b = {2'b00, r_root, 2'b01};
        end else begin
            su_a = {6'd0, r_rem[12:0], r_quo[SW-1]};
            su_b = {{(20-BW){1'b0}}, r_blk};
        end
        su_ge   = su_a >= su_b;
        su_diff = su_a - su_b;
    end

    // ---------------- clip RAM ----------------
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [16:0]   base_p1;

    assign base_p1 = r_base + 17'd1;

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = r_len[AW-1:0];
        case (r_state)
            S_SQ: begin
                ram_we = r_rec && r_first && (r_len < LW'(vtc_pkg::CLIP_FRAMES));
            end
            S_R1:    ram_addr = r_prod[16 +: AW];
            S_R2:    ram_addr = base_p1[AW-1:0];
            default: ram_addr = r_len[AW-1:0];
        endcase
    end

    vtc_ram #(.WIDTH(16), .DEPTH(vtc_pkg::CLIP_FRAMES)) u_clip_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_sample),
        .o_rdata (ram_rdata)
    );

    // ---------------- combinational helpers ----------------
    logic [SW-1:0] n_sum;
    logic [BW-1:0] n_blk;
    logic [LW-1:0] n_len;
    logic          blk_room;
    logic [17:0]   pos_base_p1;
    logic          run_go;
    logic signed [35:0] interp;
    logic signed [36:0] dbl;
    logic [31:0]        mag;
    logic               neg;
    logic [37:0]        rnd;
    logic [15:0]        crushed;
    logic               refuse;
    logic               out_free;

    always_comb begin
        blk_room = r_blk < BW'(vtc_pkg::MAX_BLOCK);
        n_sum = blk_room ? r_sum + SW'(r_prod[31:0]) : r_sum;
        n_blk = blk_room ? r_blk + BW'(1) : r_blk;
        n_len = ram_we ? r_len + LW'(1) : r_len;

        refuse = (r_maxf == 16'd0) || !r_clip_ready || (r_len < LW'(vtc_pkg::MIN_CLIP));
        pos_base_p1 = {1'b0, r_prod[32:16]} + 18'd1;
        run_go = (r_ridx < r_maxf) && (pos_base_p1 < 18'(r_len));

        interp = $signed({{4{r_s0[15]}}, r_s0, 16'd0}) + r_prod;
        dbl    = {interp, 1'b0};
        // clip to +-1.0 (2^31) before crushing
        neg = dbl[36];
        if (dbl > 37'sh0_8000_0000) begin
            mag = 32'h8000_0000;
        end else if (dbl < -37'sh0_8000_0000) begin
            mag = 32'h8000_0000;
        end else if (neg) begin
            mag = 32'(-dbl);
        end else begin
            mag = dbl[31:0];
        end

        rnd     = {1'b0, r_mag28} + 38'h0_4000_0000;
        crushed = vtc_pkg::crush_out(rnd[35:31]);
        out_free = !r_ovalid || i_out_ready;
    end

    assign o_in_ready = (r_state == S_IDLE);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_trig_lvl   <= 15'd328;
            r_rel_lvl    <= 15'd655;
            r_sum        <= '0;
            r_blk        <= '0;
            r_level      <= '0;
            r_armed      <= 1'b0;
            r_pend       <= 1'b0;
            r_rec        <= 1'b0;
            r_clip_ready <= 1'b0;
            r_len        <= '0;
            r_ridx       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index) r_rel_lvl  <= i_cfg_data;
                else             r_trig_lvl <= i_cfg_data;
            end
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req    <= i_req_type;
                        r_sample <= i_sample;
                        r_first  <= i_first_channel;
                        r_bend   <= i_block_end;
                        r_maxf   <= i_max_frames;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_sample <= '0;
                    r_res_sv     <= 1'b0;
                    r_res_last   <= 1'b0;
                    r_res_ok     <= 1'b0;
                    r_res_fc     <= '0;
                    r_res_trig   <= 1'b0;
                    r_state      <= S_IDLE;
                    case (r_req)
                        vtc_pkg::REQ_SAMPLE: r_state <= S_SQ;
                        vtc_pkg::REQ_EMPTY: begin
                            r_level <= '0;
                            r_sum   <= '0;
                            r_blk   <= '0;
                        end
                        vtc_pkg::REQ_UPDATE: begin
                            if (!r_armed && (r_level >= 16'(r_trig_lvl))) begin
                                r_armed      <= 1'b1;
                                r_pend       <= 1'b1;
                                r_len        <= '0;
                                r_rec        <= 1'b1;
                                r_clip_ready <= 1'b0;
                            end else if (r_armed && (r_level <= 16'(r_rel_lvl))) begin
                                r_armed <= 1'b0;
                                // keep recording when nothing was captured yet
                                if (r_rec && (r_len != '0)) begin
                                    r_rec        <= 1'b0;
                                    r_clip_ready <= 1'b1;
                                end
                            end
                        end
                        vtc_pkg::REQ_CONSUME: begin
                            r_res_trig <= r_pend;
                            r_pend     <= 1'b0;
                            r_state    <= S_OUT;
                        end
                        vtc_pkg::REQ_PULL: r_state <= S_R0;
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_SQ: begin
                    // square goes into r_prod; clip write happens this cycle
                    r_len <= n_len;
                    if (r_rec && r_first && (n_len >= LW'(vtc_pkg::CLIP_FRAMES))) begin
                        r_rec        <= 1'b0;
                        r_clip_ready <= 1'b1;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum   <= n_sum;
                    r_blk   <= n_blk;
                    r_state <= S_IDLE;
                    if (r_bend) begin
                        if (n_blk == '0) begin
                            r_level <= '0;
                            r_sum   <= '0;
                        end else begin
                            r_quo   <= n_sum;
                            r_rem   <= '0;
                            r_step  <= 6'(SW - 1);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    r_rem <= su_ge ? su_diff : su_a;
                    r_quo <= {r_quo[SW-2:0], su_ge};
                    r_step <= r_step - 6'd1;
                    if (r_step == '0) begin
                        r_rad   <= {r_quo[30:0], su_ge};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_step  <= 6'd15;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    // one root bit per cycle, two radicand bits in
                    r_rem  <= su_ge ? su_diff : su_a;
                    r_root <= {r_root[14:0], su_ge};
                    r_rad  <= {r_rad[29:0], 2'b00};
                    r_step <= r_step - 6'd1;
                    if (r_step == '0) begin
                        r_level <= {r_root[14:0], su_ge};
                        r_sum   <= '0;
                        r_blk   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_R0: begin
                    if (refuse) begin
                        r_ridx     <= '0;
                        r_res_last <= 1'b1;
                        r_state    <= S_OUT;
                    end else begin
                        r_state <= S_R1;
                    end
                end
                S_R1: begin
                    r_base <= r_prod[32:16];
                    r_frac <= r_prod[15:0];
                    if (run_go) begin
                        r_state <= S_R2;
                    end else begin
                        r_res_last   <= 1'b1;
                        r_res_ok     <= (r_ridx != '0);
                        r_res_fc     <= r_ridx;
                        r_clip_ready <= 1'b0;
                        r_len        <= '0;
                        r_ridx       <= '0;
                        r_state      <= S_OUT;
                    end
                end
                S_R2: begin
                    r_s0    <= $signed(ram_rdata);
                    r_state <= S_R3;
                end
                S_R3: r_state <= S_R4;
                S_R4: begin
                    r_neg   <= neg;
                    r_mag28 <= {mag, 5'd0} - {3'd0, mag, 2'd0};
                    r_state <= S_R5;
                end
                S_R5: begin
                    r_res_sample <= r_neg ? -$signed(crushed) : $signed(crushed);
                    r_res_sv     <= 1'b1;
                    r_ridx       <= r_ridx + 16'd1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output slot is free
                    if (out_free) begin
                        r_ovalid   <= 1'b1;
                        r_o_sample <= r_res_sample;
                        r_o_sv     <= r_res_sv;
                        r_o_last   <= r_res_last;
                        r_o_ok     <= r_res_ok;
                        r_o_fc     <= r_res_fc;
                        r_o_trig   <= r_res_trig;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_out_sample   = r_o_sample;
    assign o_sample_valid = r_o_sv;
    assign o_last         = r_o_last;
    assign o_ok           = r_o_ok;
    assign o_frame_count  = r_o_fc;
    assign o_triggered    = r_o_trig;

    // ---------------- assertions ----------------
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(vtc_pkg::CLIP_FRAMES))
        else $error("clip length beyond store depth");

    a_rec_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec |-> !r_clip_ready)
        else $error("recording while clip marked ready");

    a_read_in_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R2) |-> ({1'b0, base_p1} < 18'(r_len)))
        else $error("render read past clip end");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= 16'd32768)
        else $error("level out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result dropped while output slot busy");

endmodule

FILE: test/vtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtc_checker: predictor and result checker for the voice trigger clip crusher
// Watches the configuration port and both handshakes, keeps its own copy of
// the block state and compares every result with the oldest expectation.
// ----------------------------------------------------------------------------
module vtc_checker
    import vtc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [15:0] i_sample,
    input  logic               i_first_channel,
    input  logic               i_block_end,
    input  logic [15:0]        i_max_frames,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [15:0] i_out_sample,
    input  logic               i_sample_valid,
    input  logic               i_last,
    input  logic               i_ok,
    input  logic [15:0]        i_frame_count,
    input  logic               i_triggered,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic               sample_valid;
        logic               last;
        logic               ok;
        logic [15:0]        frame_count;
        logic               triggered;
    } t_result;

    localparam logic CFG_TRIGGER = 1'b0;
    localparam logic CFG_RELEASE = 1'b1;

    t_result            expected_results[$];
    logic [14:0]        trig_level;
    logic [14:0]        rel_level;
    logic [SUM_W-1:0]   sq_sum;
    logic [BLK_W-1:0]   blk_count;
    logic [16:0]        rms_level;
    logic               armed;
    logic               trig_flag;
    logic               capturing;
    logic               clip_done;
    logic [LEN_W-1:0]   clip_len;
    logic signed [15:0] clip_mem [0:CLIP_FRAMES-1];
    logic [15:0]        play_idx;

    assign o_pending = expected_results.size();

    function automatic logic [16:0] int_sqrt(input longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r = r | (64'd1 << b);
        end
        return r[16:0];
    endfunction

    // Interpolate, double, clip, crush to 28 levels and rescale.
    function automatic logic signed [15:0] crushed_frame(input logic [15:0] idx);
        longint pos, frac, s0, s1, p, c, q, o;
        longint unsigned mag;
        int     base;
        pos  = longint'(idx) * RESAMPLE_STEP;
        base = int'(pos >>> 16);
        frac = pos & 64'hFFFF;
        s0   = clip_mem[base];
        s1   = clip_mem[base + 1];
        p    = s0 * 65536 + (s1 - s0) * frac;
        c    = p * 2;
        if (c > (64'sd1 <<< 31)) c = 64'sd1 <<< 31;
        if (c < -(64'sd1 <<< 31)) c = -(64'sd1 <<< 31);
        mag  = (c < 0) ? -c : c;
        mag  = mag * CRUSH_LEVELS;
        q    = longint'((mag + (64'd1 << 30)) >> 31);
        o    = (q * 32767) / CRUSH_LEVELS;
        if (c < 0) o = -o;
        return o[15:0];
    endfunction

    task automatic predict_item(input logic [2:0] rq, input logic signed [15:0] s,
                                input logic fc, input logic be, input logic [15:0] mf);
        t_result r;
        logic [31:0] base;
        r = '0;
        case (rq)
            REQ_SAMPLE: begin
                if (blk_count < MAX_BLOCK) begin
                    sq_sum    = sq_sum + SUM_W'(longint'(s) * longint'(s));
                    blk_count = blk_count + 1'b1;
                end
                if (capturing && fc) begin
                    if (clip_len < CLIP_FRAMES) begin
                        clip_mem[clip_len[CLIP_AW-1:0]] = s;
                        clip_len = clip_len + 1'b1;
                    end
                    if (clip_len >= CLIP_FRAMES) begin
                        capturing = 1'b0;
                        clip_done = 1'b1;
                    end
                end
                if (be) begin
                    rms_level = (blk_count != 0) ? int_sqrt(sq_sum / blk_count) : '0;
                    sq_sum    = '0;
                    blk_count = '0;
                end
            end
            REQ_EMPTY: begin
                rms_level = '0;
                sq_sum    = '0;
                blk_count = '0;
            end
            REQ_UPDATE: begin
                if (!armed && rms_level >= trig_level) begin
                    armed     = 1'b1;
                    trig_flag = 1'b1;
                    clip_len  = '0;
                    capturing = 1'b1;
                    clip_done = 1'b0;
                end else if (armed && rms_level <= rel_level) begin
                    armed = 1'b0;
                    // release with an empty clip keeps recording
                    if (capturing && clip_len > 0) begin
                        capturing = 1'b0;
                        clip_done = 1'b1;
                    end
                end
            end
            REQ_CONSUME: begin
                r.triggered = trig_flag;
                trig_flag   = 1'b0;
                expected_results.push_back(r);
            end
            REQ_PULL: begin
                base = (32'(play_idx) * RESAMPLE_STEP) >> 16;
                if (mf == 0 || !clip_done || clip_len < MIN_CLIP) begin
                    play_idx = '0;
                    r.last   = 1'b1;
                end else if (play_idx < mf && base + 1 < clip_len) begin
                    r.out_sample   = crushed_frame(play_idx);
                    r.sample_valid = 1'b1;
                    play_idx       = play_idx + 1'b1;
                end else begin
                    r.last        = 1'b1;
                    r.ok          = (play_idx > 0);
                    r.frame_count = play_idx;
                    clip_done     = 1'b0;
                    clip_len      = '0;
                    play_idx      = '0;
                end
                expected_results.push_back(r);
            end
            default: ;  // unknown request: drop
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            trig_level   = 15'd328;
            rel_level    = 15'd655;
            sq_sum       = '0;
            blk_count    = '0;
            rms_level    = '0;
            armed        = 1'b0;
            trig_flag    = 1'b0;
            capturing    = 1'b0;
            clip_done    = 1'b0;
            clip_len     = '0;
            play_idx     = '0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TRIGGER) trig_level = i_cfg_data;
                else                            rel_level  = i_cfg_data;
            end
            // check results before predicting this edge's item
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    e = expected_results.pop_front();
                    if (i_out_sample != e.out_sample)
                        report_mismatch("out_sample", i_out_sample, e.out_sample);
                    if (i_sample_valid != e.sample_valid)
                        report_mismatch("sample_valid", i_sample_valid, e.sample_valid);
                    if (i_last != e.last)
                        report_mismatch("last", i_last, e.last);
                    if (i_ok != e.ok)
                        report_mismatch("ok", i_ok, e.ok);
                    if (i_frame_count != e.frame_count)
                        report_mismatch("frame_count", i_frame_count, e.frame_count);
                    if (i_triggered != e.triggered)
                        report_mismatch("triggered", i_triggered, e.triggered);
                end
            end
            if (i_in_valid && i_in_ready)
                predict_item(i_req_type, i_sample, i_first_channel, i_block_end,
                             i_max_frames);
        end
    end

endmodule

FILE: test/tb_voice_trigger_clip_pitch_crusher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voice_trigger_clip_pitch_crusher: stimulus and verdict
// Drives directed corner items, then whole trigger/record/release/render
// sessions with random content and noise, under several idle mixes, while
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_voice_trigger_clip_pitch_crusher;
    import vtc_pkg::*;

    localparam int  LIMIT_CYCLES = 2000000;
    localparam int  SETTLE       = 100;   // longer than a block-end item
    localparam logic CFG_TRIGGER = 1'b0;
    localparam logic CFG_RELEASE = 1'b1;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [14:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_req_type;
    logic signed [15:0] i_sample;
    logic               i_first_channel;
    logic               i_block_end;
    logic [15:0]        i_max_frames;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_out_sample;
    logic               o_sample_valid;
    logic               o_last;
    logic               o_ok;
    logic [15:0]        o_frame_count;
    logic               o_triggered;

    int  fail_count;
    int  pending;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  items_sent;
    int  cycle_count;
    int  hold_left;
    logic hold_req;

    voice_trigger_clip_pitch_crusher dut (.*);

    vtc_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_req_type, .i_sample,
        .i_first_channel, .i_block_end, .i_max_frames,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_sample(o_out_sample),
        .i_sample_valid(o_sample_valid), .i_last(o_last), .i_ok(o_ok),
        .i_frame_count(o_frame_count), .i_triggered(o_triggered),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Hard stop: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left   <= 300;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input logic [2:0] rq, input logic signed [15:0] s,
                             input logic fc, input logic be, input logic [15:0] mf);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= rq;
        i_sample        <= s;
        i_first_channel <= fc;
        i_block_end     <= be;
        i_max_frames    <= mf;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_ctrl(input logic [2:0] rq);
        send_item(rq, 16'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [14:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Full-scale alternating block, then an update: triggers at any threshold.
    task automatic arm_loud();
        send_item(REQ_SAMPLE, 16'sd32767, 1'b0, 1'b0, 16'd0);
        send_item(REQ_SAMPLE, -16'sd32767, 1'b0, 1'b1, 16'd0);
        send_ctrl(REQ_UPDATE);
    endtask

    // Trigger, record n frames, release, consume, then pull the clip out.
    task automatic session(input int n, input bit stereo);
        int frames;
        int pulls;
        logic [15:0] mf;
        arm_loud();
        for (int f = 0; f < n; f++) begin
            send_item(REQ_SAMPLE, 16'($urandom), 1'b1, ($urandom_range(15) == 0),
                      16'($urandom));
            if (stereo)
                send_item(REQ_SAMPLE, 16'($urandom), 1'b0, ($urandom_range(15) == 0),
                          16'($urandom));
        end
        // empty the level so any release threshold lets go, or end the block on a zero sample
        if ($urandom_range(1)) send_ctrl(REQ_EMPTY);
        else send_item(REQ_SAMPLE, 16'sd0, 1'b0, 1'b1, 16'd0);
        send_ctrl(REQ_UPDATE);
        send_ctrl(REQ_CONSUME);
        frames = 0;
        while ((((frames * RESAMPLE_STEP) >> 16) + 1) < n) frames++;
        if ($urandom_range(9) < 7) mf = 16'($urandom_range(65535, frames));
        else mf = 16'($urandom_range(frames, 1));
        pulls = frames + 1 + $urandom_range(1);
        for (int k = 0; k < pulls; k++) send_item(REQ_PULL, 16'($urandom), 1'($urandom),
                                                  1'($urandom), mf);
    endtask

    // Random items of any kind, unknown codes included.
    task automatic noise(input int count);
        for (int k = 0; k < count; k++)
            send_item(3'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                      16'($urandom));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_TRIGGER;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_req_type      = REQ_SAMPLE;
        i_sample        = '0;
        i_first_channel = 1'b0;
        i_block_end     = 1'b0;
        i_max_frames    = '0;
        i_out_ready     = 1'b1;
        hold_req        = 1'b0;
        hold_left       = 0;
        cycle_count     = 0;
        items_sent      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: flag and pulls from reset, zero frame limit, unknown codes.
        send_ctrl(REQ_CONSUME);
        send_item(REQ_PULL, 16'sd0, 1'b0, 1'b0, 16'd5);
        send_item(REQ_PULL, 16'sd0, 1'b0, 1'b0, 16'd0);
        send_item(3'd5, 16'sd0, 1'b0, 1'b0, 16'd0);
        send_item(3'd7, 16'sd0, 1'b0, 1'b0, 16'd0);
        send_ctrl(REQ_EMPTY);
        // Extreme samples, trigger, then release while the clip is still empty.
        send_item(REQ_SAMPLE, -16'sd32768, 1'b0, 1'b0, 16'd0);
        send_item(REQ_SAMPLE, 16'sd32767, 1'b0, 1'b1, 16'd0);
        send_ctrl(REQ_UPDATE);
        send_ctrl(REQ_CONSUME);
        send_ctrl(REQ_EMPTY);
        send_ctrl(REQ_UPDATE);
        // Recording goes on: a short clip, a retrigger that drops it, then a pull that is refused.
        for (int k = 0; k < 6; k++)
            send_item(REQ_SAMPLE, (k % 2) ? 16'sd32767 : -16'sd32768, 1'b1,
                      (k == 5), 16'hFFFF);
        arm_loud();
        send_ctrl(REQ_EMPTY);
        send_ctrl(REQ_UPDATE);
        send_item(REQ_PULL, 16'sd0, 1'b0, 1'b0, 16'hFFFF);
        send_ctrl(REQ_CONSUME);
        drain();

        // Random sessions under rotating idle mixes and register settings.
        for (int ph = 0; items_sent < 600; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            case (ph)
                0: begin write_reg(CFG_TRIGGER, 15'd0);     write_reg(CFG_RELEASE, 15'h7FFF); end
                1: begin write_reg(CFG_TRIGGER, 15'h7FFF);  write_reg(CFG_RELEASE, 15'd0);    end
                default: begin
                    write_reg(CFG_TRIGGER, 15'($urandom));
                    write_reg(CFG_RELEASE, 15'($urandom));
                end
            endcase
            session(($urandom_range(7) == 0) ? $urandom_range(63, 58) : $urandom_range(90, 64),
                    $urandom_range(1));
            noise($urandom_range(40, 15));
            drain();
        end

        // Clip fills the store inside one overlong block; pull a limited run.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_TRIGGER, 15'd328);
        write_reg(CFG_RELEASE, 15'd655);
        arm_loud();
        for (int k = 0; k < CLIP_FRAMES + 100; k++)
            send_item(REQ_SAMPLE, 16'($urandom), 1'b1, (k == CLIP_FRAMES + 99), 16'd0);
        send_ctrl(REQ_CONSUME);
        for (int k = 0; k < 42; k++) send_item(REQ_PULL, 16'sd0, 1'b0, 1'b0, 16'd40);

        // Hold the receiver off while consumes pile up and stall the input.
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        for (int k = 0; k < 12; k++) send_ctrl(REQ_CONSUME);
        drain();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
